### hw/rtl/rbd_pkg.sv
// Shared types and constants for the ring buffer deque.
`timescale 1ns / 1ps

package rbd_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned ADDR_W    = 3;

  // Register index, taken from the upper address bit.
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [1:0] {
    OP_PUSH_REAR  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE       = 2'd0,
    ST_FULL       = 2'd1,
    ST_EMPTY      = 2'd2
  } status_e;

  typedef struct packed {
    logic shift_r;    // push at the front: every entry moves one cell up
    logic shift_l;    // pop at the front: every entry moves one cell down
    logic load_rear;  // push at the rear: the cell at the count takes the value
  } cell_ctrl_t;

endpackage

### hw/rtl/rbd_cell.sv
// One storage cell of the deque row: holds one entry and trades it with its neighbors.
`timescale 1ns / 1ps

module rbd_cell #(
  parameter int unsigned DEPTH = rbd_pkg::DEPTH_DEF,
  parameter int unsigned IDX   = 0,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                        clk_i,
  input  rbd_pkg::cell_ctrl_t         ctrl_i,
  input  logic [CNT_W-1:0]            count_i,
  input  logic [rbd_pkg::DATA_W-1:0]  push_value_i,
  input  logic [rbd_pkg::DATA_W-1:0]  left_i,
  input  logic [rbd_pkg::DATA_W-1:0]  right_i,
  output logic [rbd_pkg::DATA_W-1:0]  value_o,
  output logic [rbd_pkg::DATA_W-1:0]  tap_o
);

  logic [rbd_pkg::DATA_W-1:0] value_q;
  logic [rbd_pkg::DATA_W-1:0] value_d;
  logic                       at_count;
  logic                       is_rear;

  assign at_count = (count_i == CNT_W'(IDX));
  assign is_rear  = (count_i == CNT_W'(IDX + 1));

  always_comb begin
    value_d = value_q;
    if (ctrl_i.shift_r) begin
      value_d = left_i;
    end else if (ctrl_i.shift_l) begin
      value_d = right_i;
    end else if (ctrl_i.load_rear && at_count) begin
      value_d = push_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  // Only the last held entry shows on the rear read bus.
  assign tap_o   = is_rear ? value_q : '0;

endmodule

### hw/rtl/ring_buffer_deque.sv
// Top level of the ring buffer deque: cell row, count and capacity control, result register.
`timescale 1ns / 1ps

// A double-ended queue of up to DEPTH signed 32-bit entries. Each request names one of
// four operations (push rear, push front, pop front, pop rear) and yields exactly one
// result with a status, the popped value and the empty, full and count flags after the
// operation. Entries live in a row of cells with the front always in the first cell; a
// front push or pop moves the whole row by one cell, a rear push writes
// the cell at the current count, and a rear pop reads the last held cell through an OR
// bus. A request is taken every cycle as long as the result register is free or its
// result is taken in the same cycle; the result shows in the cycle after the request.
// Writing the capacity register (address 0) empties the deque; zero reads as one and
// values above DEPTH saturate to DEPTH. No clearing pass is needed after reset.
module ring_buffer_deque #(
  parameter int unsigned DEPTH = rbd_pkg::DEPTH_DEF,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rbd_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  // Request channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  operation_i,
  input  logic signed [31:0]          push_value_i,
  // Result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  status_o,
  output logic signed [31:0]          popped_value_o,
  output logic                        is_empty_o,
  output logic                        is_full_o,
  output logic [CNT_W-1:0]            entry_count_o
);

  logic [CNT_W-1:0]            cap_q;
  logic [CNT_W-1:0]            cap_d;
  logic [CNT_W-1:0]            count_q;
  logic [CNT_W-1:0]            count_d;
  logic [CNT_W-1:0]            count_next;
  logic                        cfg_write;
  logic                        accept;
  logic                        full;
  logic                        empty;
  rbd_pkg::op_e                op;
  rbd_pkg::status_e            status;
  rbd_pkg::cell_ctrl_t         op_ctrl;
  rbd_pkg::cell_ctrl_t         cell_ctrl;
  logic [31:0]                 popped;
  logic [31:0]                 rear_value;

  logic [DEPTH-1:0][31:0]      cell_value;
  logic [DEPTH-1:0][31:0]      cell_tap;

  logic                        out_valid_q;
  logic [1:0]                  status_q;
  logic [31:0]                 popped_q;
  logic                        is_empty_q;
  logic                        is_full_q;
  logic [CNT_W-1:0]            count_out_q;

  // Configuration
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == rbd_pkg::REG_CAPACITY);
  assign prdata    = (paddr[2] == rbd_pkg::REG_CAPACITY) ? 32'(cap_q) : '0;

  always_comb begin
    if (pwdata == '0) begin
      cap_d = CNT_W'(1);
    end else if (pwdata > 32'(DEPTH)) begin
      cap_d = CNT_W'(DEPTH);
    end else begin
      cap_d = pwdata[CNT_W-1:0];
    end
  end

  // Request decode
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign op         = rbd_pkg::op_e'(operation_i);
  assign full       = (count_q >= cap_q);
  assign empty      = (count_q == '0);

  always_comb begin
    rear_value = '0;
    for (int i = 0; i < int'(DEPTH); i++) begin
      rear_value = rear_value | cell_tap[i];
    end
  end

  always_comb begin
    status     = rbd_pkg::ST_DONE;
    popped     = '0;
    op_ctrl    = '0;
    count_next = count_q;
    unique case (op)
      rbd_pkg::OP_PUSH_REAR: begin
        if (full) begin
          status = rbd_pkg::ST_FULL;
        end else begin
          op_ctrl.load_rear = 1'b1;
          count_next        = count_q + CNT_W'(1);
        end
      end
      rbd_pkg::OP_PUSH_FRONT: begin
        if (full) begin
          status = rbd_pkg::ST_FULL;
        end else begin
          op_ctrl.shift_r = 1'b1;
          count_next      = count_q + CNT_W'(1);
        end
      end
      rbd_pkg::OP_POP_FRONT: begin
        if (empty) begin
          status = rbd_pkg::ST_EMPTY;
        end else begin
          popped          = cell_value[0];
          op_ctrl.shift_l = 1'b1;
          count_next      = count_q - CNT_W'(1);
        end
      end
      rbd_pkg::OP_POP_REAR: begin
        if (empty) begin
          status = rbd_pkg::ST_EMPTY;
        end else begin
          popped     = rear_value;
          count_next = count_q - CNT_W'(1);
        end
      end
      default: begin
        status = rbd_pkg::ST_DONE;
      end
    endcase
  end

  assign cell_ctrl = accept ? op_ctrl : '0;

  always_comb begin
    count_d = count_q;
    if (cfg_write) begin
      count_d = '0;
    end else if (accept) begin
      count_d = count_next;
    end
  end

  // Cell row; the first cell takes a front push, the last one keeps its own value on a pop.
  for (genvar g = 0; g < int'(DEPTH); g++) begin : g_cell
    logic [31:0] left;
    logic [31:0] right;
    if (g == 0) begin : g_first
      assign left = push_value_i;
    end else begin : g_inner_l
      assign left = cell_value[g-1];
    end
    if (g == int'(DEPTH) - 1) begin : g_last
      assign right = cell_value[g];
    end else begin : g_inner_r
      assign right = cell_value[g+1];
    end
    rbd_cell #(
      .DEPTH (DEPTH),
      .IDX   (g)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (cell_ctrl),
      .count_i      (count_q),
      .push_value_i (push_value_i),
      .left_i       (left),
      .right_i      (right),
      .value_o      (cell_value[g]),
      .tap_o        (cell_tap[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CNT_W'(DEPTH);
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cfg_write) begin
        cap_q <= cap_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q    <= status;
      popped_q    <= popped;
      is_empty_q  <= (count_next == '0);
      is_full_q   <= (count_next == cap_q);
      count_out_q <= count_next;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign popped_value_o = popped_q;
  assign is_empty_o     = is_empty_q;
  assign is_full_o      = is_full_q;
  assign entry_count_o  = count_out_q;

endmodule
